[sv/obm_pkg.sv]
`timescale 1ns / 1ps

package obm_pkg;

  // Command codes carried in in_tuser
  localparam logic [2:0] CMD_TICK  = 3'd0;
  localparam logic [2:0] CMD_RESET = 3'd1;
  localparam logic [2:0] CMD_WBIT  = 3'd2;
  localparam logic [2:0] CMD_RBIT  = 3'd3;
  localparam logic [2:0] CMD_WBYTE = 3'd4;
  localparam logic [2:0] CMD_TOUCH = 3'd5;

  // Slot timing letters
  localparam logic [3:0] LT_A = 4'd0;
  localparam logic [3:0] LT_B = 4'd1;
  localparam logic [3:0] LT_C = 4'd2;
  localparam logic [3:0] LT_D = 4'd3;
  localparam logic [3:0] LT_E = 4'd4;
  localparam logic [3:0] LT_F = 4'd5;
  localparam logic [3:0] LT_G = 4'd6;
  localparam logic [3:0] LT_H = 4'd7;
  localparam logic [3:0] LT_I = 4'd8;
  localparam logic [3:0] LT_J = 4'd9;

  localparam int TIMING_W = 12;

  typedef enum logic [5:0] {
    OP_IDLE  = 6'b000001,
    OP_RESET = 6'b000010,
    OP_WBIT  = 6'b000100,
    OP_RBIT  = 6'b001000,
    OP_WBYTE = 6'b010000,
    OP_TOUCH = 6'b100000
  } op_t;

  typedef enum logic [1:0] {
    K_RESET = 2'd0,
    K_W1    = 2'd1,
    K_W0    = 2'd2,
    K_READ  = 2'd3
  } kind_t;

  typedef struct packed {
    op_t        op;
    logic [2:0] phase;
    logic [3:0] bit_idx;
    logic [7:0] tx;
    logic [7:0] rx;
    logic       pres;
  } st_t;

  typedef struct packed {
    logic       rejected;
    logic       no_presence;
    logic [7:0] read_data;
    logic       done;
    logic       busy;
    logic       drive_low;
  } res_t;

  // Slot lengths in 166 ns ticks: standard / overdrive
  function automatic logic [TIMING_W-1:0] timing(input logic od, input logic [3:0] lt);
    logic [TIMING_W-1:0] t;
    t = '0;
    case (lt)
      LT_A: t = od ? TIMING_W'(9)  : TIMING_W'(6 * 6);
      LT_B: t = od ? TIMING_W'(45) : TIMING_W'(64 * 6);
      LT_C: t = od ? TIMING_W'(45) : TIMING_W'(60 * 6);
      LT_D: t = od ? TIMING_W'(15) : TIMING_W'(10 * 6);
      LT_E: t = od ? TIMING_W'(4)  : TIMING_W'(9 * 6);
      LT_F: t = od ? TIMING_W'(7 * 6) : TIMING_W'(55 * 6);
      LT_G: t = od ? TIMING_W'(15) : TIMING_W'(0);
      LT_H: t = od ? TIMING_W'(70 * 6) : TIMING_W'(480 * 6);
      LT_I: t = od ? TIMING_W'(51) : TIMING_W'(70 * 6);
      LT_J: t = od ? TIMING_W'(40 * 6) : TIMING_W'(410 * 6);
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic kind_t slot_kind(input op_t op, input logic tx0);
    kind_t k;
    k = tx0 ? K_W1 : K_W0;
    case (op)
      OP_RESET: k = K_RESET;
      OP_RBIT:  k = K_READ;
      OP_TOUCH: k = tx0 ? K_READ : K_W0;
      default:  k = tx0 ? K_W1 : K_W0;
    endcase
    return k;
  endfunction

  function automatic logic [2:0] slot_phases(input kind_t k);
    logic [2:0] n;
    n = 3'd2;
    case (k)
      K_RESET: n = 3'd4;
      K_READ:  n = 3'd3;
      default: n = 3'd2;
    endcase
    return n;
  endfunction

  function automatic logic [3:0] slot_letter(input kind_t k, input logic [1:0] p);
    logic [3:0] lt;
    lt = LT_A;
    case (k)
      K_RESET: begin
        case (p)
          2'd0:    lt = LT_G;
          2'd1:    lt = LT_H;
          2'd2:    lt = LT_I;
          default: lt = LT_J;
        endcase
      end
      K_W1:    lt = (p == 2'd0) ? LT_A : LT_B;
      K_W0:    lt = (p == 2'd0) ? LT_C : LT_D;
      default: begin
        case (p)
          2'd0:    lt = LT_A;
          2'd1:    lt = LT_E;
          default: lt = LT_F;
        endcase
      end
    endcase
    return lt;
  endfunction

  function automatic logic slot_low(input kind_t k, input logic [1:0] p);
    return (k == K_RESET) ? (p == 2'd1) : (p == 2'd0);
  endfunction

  function automatic logic slot_sample(input kind_t k, input logic [1:0] p);
    return ((k == K_RESET) && (p == 2'd2)) || ((k == K_READ) && (p == 2'd1));
  endfunction

  function automatic st_t take_sample(input st_t s, input logic line);
    st_t r;
    r = s;
    if (s.op == OP_RESET) r.pres = line;
    else if (s.op == OP_RBIT) r.rx = {7'd0, line};
    else if (line) r.rx[7] = 1'b1;
    return r;
  endfunction

endpackage

[sv/obm_core.sv]
`timescale 1ns / 1ps

module obm_core import obm_pkg::*; #(
  parameter int DELAY_BITS = 12
) (
  input  st_t                   st,
  input  logic [DELAY_BITS-1:0] dc,
  input  logic [2:0]            cmd,
  input  logic [7:0]            data_byte,
  input  logic                  line_sample,
  input  logic                  overdrive_mode,
  output st_t                   st_nxt,
  output logic [DELAY_BITS-1:0] dc_nxt,
  output res_t                  res_nxt
);

  // at most one empty phase or one bit rollover precedes a timed phase
  localparam int ENTER_STEPS = 2;

  always_comb begin
    st_t                   s;
    logic [DELAY_BITS-1:0] d;
    kind_t                 k;
    logic                  go;
    logic                  more;
    res_t                  r;

    s    = st;
    d    = dc;
    go   = 1'b0;
    more = 1'b0;
    r    = '0;
    k    = slot_kind(s.op, s.tx[0]);

    case (cmd) inside
      CMD_TICK: begin
        if (s.op != OP_IDLE) begin
          if (d != '0) d = d - 1'b1;
          if (d == '0) begin
            k = slot_kind(s.op, s.tx[0]);
            if ((s.phase < slot_phases(k)) && slot_sample(k, s.phase[1:0]))
              s = take_sample(s, line_sample);
            s.phase = s.phase + 3'd1;
            go = 1'b1;
          end
        end
      end
      CMD_RESET, CMD_WBIT, CMD_RBIT, CMD_WBYTE, CMD_TOUCH: begin
        if (s.op != OP_IDLE) begin
          r.rejected = 1'b1;
        end else begin
          case (cmd)
            CMD_RESET: s.op = OP_RESET;
            CMD_WBIT:  s.op = OP_WBIT;
            CMD_RBIT:  s.op = OP_RBIT;
            CMD_WBYTE: s.op = OP_WBYTE;
            default:   s.op = OP_TOUCH;
          endcase
          s.phase   = 3'd0;
          s.bit_idx = 4'd0;
          s.tx      = (cmd == CMD_WBIT) ? {7'd0, data_byte[0]} : data_byte;
          s.rx      = 8'd0;
          s.pres    = 1'b0;
          go        = 1'b1;
        end
      end
      default: ;
    endcase

    // phase entry: skip empty phases, roll over to the next bit or finish
    for (int i = 0; i < ENTER_STEPS; i++) begin
      if (go) begin
        k = slot_kind(s.op, s.tx[0]);
        if (s.phase >= slot_phases(k)) begin
          more = 1'b0;
          if ((s.op == OP_WBYTE) || (s.op == OP_TOUCH)) begin
            s.bit_idx = s.bit_idx + 4'd1;
            s.tx      = {1'b0, s.tx[7:1]};
            if (s.bit_idx < 4'd8) begin
              s.phase = 3'd0;
              s.rx    = {1'b0, s.rx[7:1]};
              more    = 1'b1;
            end
          end
          if (!more) begin
            r.done        = 1'b1;
            r.read_data   = ((s.op == OP_RBIT) || (s.op == OP_TOUCH)) ? s.rx : 8'd0;
            r.no_presence = (s.op == OP_RESET) ? s.pres : 1'b0;
            s.op          = OP_IDLE;
            s.phase       = 3'd0;
            d             = '0;
            go            = 1'b0;
          end
        end else begin
          d = DELAY_BITS'(timing(overdrive_mode, slot_letter(k, s.phase[1:0])));
          if (d != '0) begin
            go = 1'b0;
          end else begin
            if (slot_sample(k, s.phase[1:0])) s = take_sample(s, line_sample);
            s.phase = s.phase + 3'd1;
          end
        end
      end
    end

    k           = slot_kind(s.op, s.tx[0]);
    r.busy      = (s.op != OP_IDLE);
    r.drive_low = r.busy && slot_low(k, s.phase[1:0]);

    st_nxt  = s;
    dc_nxt  = d;
    res_nxt = r;
  end

endmodule

[sv/onewire_bus_master.sv]
`timescale 1ns / 1ps

// 1-Wire bus master. Each input beat is either a timer tick (every 166 ns, carrying the
// sampled bus level) or a command: reset with presence detect, write bit, read bit, write
// byte or touch byte. Every accepted beat gives exactly one result beat with the bus drive
// level and busy/done status as they stand after it; done beats also carry the read data or
// the presence result. One beat is accepted per clock cycle and its result appears on the
// next cycle: the whole slot update is a single pass of logic into one result register,
// and a new beat is taken whenever that register is empty or being read out. Commands
// arriving while an operation runs are dropped and flagged as rejected. overdrive_mode
// picks the slot timings and is applied at the start of each slot phase.
module onewire_bus_master import obm_pkg::*; #(
  parameter int DELAY_BITS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] data_byte, [8] line_sample, [15:9] zero
  input  logic [2:0]  in_tuser,   // [2:0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] drive_low, [1] busy_res, [2] done_res, [10:3] read_data, [11] no_presence,
  // [12] rejected, [15:13] zero
  output logic [15:0] out_tdata,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data
);

  st_t                   st_r;
  st_t                   st_nxt;
  logic [DELAY_BITS-1:0] dc_r;
  logic [DELAY_BITS-1:0] dc_nxt;
  logic                  mode_r;
  res_t                  res_r;
  res_t                  res_nxt;
  logic                  out_valid_r;
  logic                  in_acc;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  obm_core #(.DELAY_BITS(DELAY_BITS)) u_core (
    .st             (st_r),
    .dc             (dc_r),
    .cmd            (in_tuser),
    .data_byte      (in_tdata[7:0]),
    .line_sample    (in_tdata[8]),
    .overdrive_mode (mode_r),
    .st_nxt         (st_nxt),
    .dc_nxt         (dc_nxt),
    .res_nxt        (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '{op: OP_IDLE, phase: 3'd0, bit_idx: 4'd0, tx: 8'd0, rx: 8'd0,
                       pres: 1'b0};
      dc_r        <= '0;
      mode_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) mode_r <= cfg_wr_data;
      if (in_acc) begin
        st_r        <= st_nxt;
        dc_r        <= dc_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) res_r <= res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, res_r};

  // a running operation always has a timed phase pending
  a_busy_timed: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.op != OP_IDLE) |-> (dc_r != '0))
    else $error("busy with zero delay count");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.done) |-> (!res_r.busy && !res_r.rejected))
    else $error("done beat still busy or rejected");

  a_drive_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.drive_low) |-> res_r.busy)
    else $error("bus driven low while idle");

  a_no_reject_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (st_r.op == OP_IDLE)) |=> !res_r.rejected)
    else $error("command rejected while idle");

endmodule

[dv/onewire_bus_master_tb.sv]
`timescale 1ns / 1ps

module onewire_bus_master_tb;
  import obm_pkg::*;

  localparam int DELAY_BITS  = 12;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_PRINTED = 100;

  // command codes the block must ignore
  localparam logic [2:0] CMD_UNUSED6 = 3'd6;
  localparam logic [2:0] CMD_UNUSED7 = 3'd7;

  // bus level offered on tick beats
  localparam int LINE_LOW    = 0;
  localparam int LINE_HIGH   = 1;
  localparam int LINE_RANDOM = 2;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [7:0] data_byte, [8] line_sample, [15:9] zero
  logic [2:0]  in_tuser;   // [2:0] command
  logic        out_tvalid;
  logic        out_tready;
  // [0] drive_low, [1] busy_res, [2] done_res, [10:3] read_data, [11] no_presence,
  // [12] rejected, [15:13] zero
  logic [15:0] out_tdata;
  logic        cfg_wr_en;
  logic        cfg_wr_data;

  int          tx_gap_pct;
  int          rx_stall_pct;
  bit          hold_go;
  int unsigned mismatches;
  int unsigned results_checked;
  res_t        status_q[$];
  res_t        got_st;
  res_t        want_st;

  // predicted master state
  logic                  bus_od;
  op_t                   bus_op;
  logic [2:0]            bus_phase;
  logic [DELAY_BITS-1:0] bus_count;
  logic [3:0]            bus_bit;
  logic [7:0]            bus_tx;
  logic [7:0]            bus_rx;
  logic                  bus_pres;
  logic                  fin_done;
  logic [7:0]            fin_data;
  logic                  fin_nopres;

  onewire_bus_master i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------- predictor

  function automatic kind_t bus_kind();
    case (bus_op)
      OP_RESET: return K_RESET;
      OP_RBIT:  return K_READ;
      OP_TOUCH: return bus_tx[0] ? K_READ : K_W0;
      default:  return bus_tx[0] ? K_W1 : K_W0;
    endcase
  endfunction

  function automatic logic [2:0] phase_total(input kind_t k);
    case (k)
      K_RESET: return 3'd4;
      K_READ:  return 3'd3;
      default: return 3'd2;
    endcase
  endfunction

  // phase lengths in ticks; overdrive F is 7*6, not 0
  function automatic int unsigned phase_len(input logic od, input kind_t k,
                                            input logic [2:0] p);
    case (k)
      K_RESET: begin
        case (p)
          3'd0:    return od ? 15  : 0;
          3'd1:    return od ? 420 : 2880;
          3'd2:    return od ? 51  : 420;
          default: return od ? 240 : 2460;
        endcase
      end
      K_W1:    return (p == 3'd0) ? (od ? 9 : 36)  : (od ? 45 : 384);
      K_W0:    return (p == 3'd0) ? (od ? 45 : 360) : (od ? 15 : 60);
      default: begin
        case (p)
          3'd0:    return od ? 9  : 36;
          3'd1:    return od ? 4  : 54;
          default: return od ? 42 : 330;
        endcase
      end
    endcase
  endfunction

  function automatic logic samples_here(input kind_t k, input logic [2:0] p);
    return ((k == K_RESET) && (p == 3'd2)) || ((k == K_READ) && (p == 3'd1));
  endfunction

  function automatic logic pulls_low(input kind_t k, input logic [2:0] p);
    return (k == K_RESET) ? (p == 3'd1) : (p == 3'd0);
  endfunction

  function automatic void bus_sample(input logic line);
    if (bus_op == OP_RESET) bus_pres = line;
    else if (bus_op == OP_RBIT) bus_rx = {7'd0, line};
    else if (line) bus_rx[7] = 1'b1;
  endfunction

  // load the current phase; empty phases are passed through, finished slots
  // move on to the next bit or close the operation
  function automatic void bus_enter(input logic line);
    kind_t k;
    logic  stop;
    logic  byte_op;
    stop = 1'b0;
    while (!stop) begin
      k = bus_kind();
      byte_op = (bus_op == OP_WBYTE) || (bus_op == OP_TOUCH);
      if (bus_phase < phase_total(k)) begin
        bus_count = DELAY_BITS'(phase_len(bus_od, k, bus_phase));
        if (bus_count != '0) begin
          stop = 1'b1;
        end else begin
          if (samples_here(k, bus_phase)) bus_sample(line);
          bus_phase++;
        end
      end else begin
        if (byte_op) begin
          bus_bit++;
          bus_tx = bus_tx >> 1;
        end
        if (byte_op && (bus_bit < 4'd8)) begin
          bus_phase = '0;
          bus_rx = bus_rx >> 1;
        end else begin
          fin_done   = 1'b1;
          fin_data   = ((bus_op == OP_RBIT) || (bus_op == OP_TOUCH)) ? bus_rx : 8'd0;
          fin_nopres = (bus_op == OP_RESET) ? bus_pres : 1'b0;
          bus_op     = OP_IDLE;
          bus_phase  = '0;
          bus_count  = '0;
          stop       = 1'b1;
        end
      end
    end
  endfunction

  function automatic res_t bus_step(input logic [2:0] cmd, input logic [7:0] data,
                                    input logic line);
    res_t  r;
    kind_t k;
    logic  rej;
    rej        = 1'b0;
    fin_done   = 1'b0;
    fin_data   = 8'd0;
    fin_nopres = 1'b0;
    if (cmd == CMD_TICK) begin
      if (bus_op != OP_IDLE) begin
        if (bus_count != '0) bus_count--;
        if (bus_count == '0) begin
          k = bus_kind();
          if ((bus_phase < phase_total(k)) && samples_here(k, bus_phase)) bus_sample(line);
          bus_phase++;
          bus_enter(line);
        end
      end
    end else if (cmd <= CMD_TOUCH) begin
      if (bus_op != OP_IDLE) begin
        rej = 1'b1;
      end else begin
        case (cmd)
          CMD_RESET: bus_op = OP_RESET;
          CMD_WBIT:  bus_op = OP_WBIT;
          CMD_RBIT:  bus_op = OP_RBIT;
          CMD_WBYTE: bus_op = OP_WBYTE;
          default:   bus_op = OP_TOUCH;
        endcase
        bus_phase = '0;
        bus_bit   = '0;
        bus_tx    = (cmd == CMD_WBIT) ? {7'd0, data[0]} : data;
        bus_rx    = '0;
        bus_pres  = 1'b0;
        bus_enter(line);
      end
    end
    r.drive_low   = (bus_op != OP_IDLE) && pulls_low(bus_kind(), bus_phase);
    r.busy        = (bus_op != OP_IDLE);
    r.done        = fin_done;
    r.read_data   = fin_data;
    r.no_presence = fin_nopres;
    r.rejected    = rej;
    return r;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("%0t: result beat %0d: %s is %0h, expected %0h",
               $realtime, results_checked, what, got, want);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_st = res_t'(out_tdata[12:0]);
      if (status_q.size() == 0) begin
        report_mismatch("unexpected beat", out_tdata, 0);
      end else begin
        want_st = status_q.pop_front();
        if (got_st.drive_low !== want_st.drive_low)
          report_mismatch("drive_low", got_st.drive_low, want_st.drive_low);
        if (got_st.busy !== want_st.busy)
          report_mismatch("busy", got_st.busy, want_st.busy);
        if (got_st.done !== want_st.done)
          report_mismatch("done", got_st.done, want_st.done);
        if (got_st.read_data !== want_st.read_data)
          report_mismatch("read_data", got_st.read_data, want_st.read_data);
        if (got_st.no_presence !== want_st.no_presence)
          report_mismatch("no_presence", got_st.no_presence, want_st.no_presence);
        if (got_st.rejected !== want_st.rejected)
          report_mismatch("rejected", got_st.rejected, want_st.rejected);
        if (out_tdata[15:13] !== 3'd0)
          report_mismatch("pad bits", out_tdata[15:13], 0);
      end
      results_checked++;
    end
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin : rx_ready_gen
    int unsigned hold_left;
    hold_left  = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_go   = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic logic line_for(input int sel);
    return (sel == LINE_RANDOM) ? 1'($urandom_range(0, 1)) : sel[0];
  endfunction

  task automatic send_beat(input logic [2:0] cmd, input logic [7:0] data, input logic line);
    while ($urandom_range(0, 99) < tx_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {7'd0, line, data};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    status_q.push_back(bus_step(cmd, data, line));
  endtask

  // lowers valid and waits for every outstanding result beat
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (status_q.size() != 0);
  endtask

  task automatic set_mode(input logic od);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= od;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    bus_od = od;
  endtask

  // ticks (with the odd stray command) until the running operation closes
  task automatic finish_op(input int sel, input int noise_pct);
    while (bus_op != OP_IDLE) begin
      if ($urandom_range(0, 99) < noise_pct)
        send_beat(3'($urandom_range(CMD_RESET, CMD_UNUSED7)), 8'($urandom), line_for(sel));
      else
        send_beat(CMD_TICK, 8'($urandom), line_for(sel));
    end
  endtask

  task automatic run_op(input logic [2:0] cmd, input logic [7:0] data, input int sel,
                        input int noise_pct);
    send_beat(cmd, data, line_for(sel));
    finish_op(sel, noise_pct);
  endtask

  task automatic test_idle_beats();
    send_beat(CMD_TICK, 8'h00, 1'b0);
    send_beat(CMD_TICK, 8'hFF, 1'b1);
    send_beat(CMD_UNUSED6, 8'hFF, 1'b1);
    send_beat(CMD_UNUSED7, 8'h00, 1'b0);
    send_beat(CMD_TICK, 8'h5A, 1'b1);
  endtask

  // standard reset has a zero-length first release phase
  task automatic test_bus_reset();
    set_mode(1'b0);
    run_op(CMD_RESET, 8'h00, LINE_LOW, 0);
    run_op(CMD_RESET, 8'hFF, LINE_HIGH, 0);
    set_mode(1'b1);
    run_op(CMD_RESET, 8'h00, LINE_LOW, 0);
    run_op(CMD_RESET, 8'hFF, LINE_HIGH, 0);
  endtask

  task automatic test_bit_slots();
    set_mode(1'b0);
    run_op(CMD_WBIT, 8'hFE, LINE_RANDOM, 0);
    run_op(CMD_WBIT, 8'h01, LINE_RANDOM, 0);
    run_op(CMD_RBIT, 8'hFF, LINE_LOW, 0);
    set_mode(1'b1);
    run_op(CMD_WBIT, 8'hFE, LINE_RANDOM, 0);
    run_op(CMD_WBIT, 8'h01, LINE_RANDOM, 0);
    run_op(CMD_RBIT, 8'h00, LINE_HIGH, 0);
  endtask

  task automatic test_byte_slots();
    set_mode(1'b1);
    run_op(CMD_WBYTE, 8'h00, LINE_RANDOM, 0);
    run_op(CMD_WBYTE, 8'hFF, LINE_RANDOM, 0);
    run_op(CMD_TOUCH, 8'h00, LINE_HIGH, 0);
    run_op(CMD_TOUCH, 8'hFF, LINE_HIGH, 0);
    set_mode(1'b0);
    run_op(CMD_WBYTE, 8'h5A, LINE_RANDOM, 0);
    run_op(CMD_TOUCH, 8'hC3, LINE_RANDOM, 0);
  endtask

  task automatic test_busy_commands();
    set_mode(1'b1);
    send_beat(CMD_RBIT, 8'h00, 1'b0);
    send_beat(CMD_TICK, 8'h00, 1'b1);
    for (int c = CMD_RESET; c <= CMD_UNUSED7; c++)
      send_beat(3'(c), 8'hFF, 1'b1);
    finish_op(LINE_RANDOM, 0);
  endtask

  // a new mode only takes effect when the next phase is loaded
  task automatic test_mode_switch_midslot();
    set_mode(1'b1);
    send_beat(CMD_WBIT, 8'h00, 1'b0);
    repeat (10) send_beat(CMD_TICK, 8'($urandom), 1'b1);
    set_mode(1'b0);
    finish_op(LINE_RANDOM, 0);
    send_beat(CMD_RBIT, 8'h00, 1'b0);
    repeat (5) send_beat(CMD_TICK, 8'($urandom), 1'b0);
    set_mode(1'b1);
    finish_op(LINE_HIGH, 0);
  endtask

  task automatic test_input_stall();
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    set_mode(1'b1);
    hold_go = 1'b1;
    run_op(CMD_WBYTE, 8'h96, LINE_RANDOM, 0);
  endtask

  task automatic test_random(input int gap, input int stall, input int n_ops);
    logic [2:0] cmd;
    int         sel;
    int         r;
    tx_gap_pct   = gap;
    rx_stall_pct = stall;
    repeat (n_ops) begin
      if ($urandom_range(0, 5) == 0) set_mode($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 2))
          0:       send_beat(CMD_TICK, 8'($urandom), 1'($urandom));
          1:       send_beat(CMD_UNUSED6, 8'($urandom), 1'($urandom));
          default: send_beat(CMD_UNUSED7, 8'($urandom), 1'($urandom));
        endcase
      end
      // standard slots are long: keep mostly to single bits there
      if (bus_od) begin
        cmd = 3'($urandom_range(CMD_RESET, CMD_TOUCH));
      end else begin
        r = $urandom_range(0, 9);
        if (r < 7) cmd = 3'($urandom_range(CMD_WBIT, CMD_RBIT));
        else if (r < 9) cmd = 3'($urandom_range(CMD_WBYTE, CMD_TOUCH));
        else cmd = CMD_RESET;
      end
      sel = ($urandom_range(0, 3) == 0) ? $urandom_range(LINE_LOW, LINE_HIGH) : LINE_RANDOM;
      run_op(cmd, 8'($urandom), sel, 4);
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    in_tvalid       = 1'b0;
    in_tdata        = '0;
    in_tuser        = CMD_TICK;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = 1'b0;
    hold_go         = 1'b0;
    mismatches      = 0;
    results_checked = 0;
    bus_od          = 1'b0;
    bus_op          = OP_IDLE;
    bus_phase       = '0;
    bus_count       = '0;
    bus_bit         = '0;
    bus_tx          = '0;
    bus_rx          = '0;
    bus_pres        = 1'b0;
    tx_gap_pct      = 24;
    rx_stall_pct    = 68;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_beats();
    test_bus_reset();
    test_bit_slots();
    test_byte_slots();
    test_busy_commands();
    test_mode_switch_midslot();
    test_random(24, 68, 40);
    test_random(68, 24, 40);
    test_input_stall();
    test_random(0, 0, 40);

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && status_q.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin : watchdog
    #50ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
